FILE: src/upt_pkg.sv
// ============================================================================
// upt_pkg
// Shared types, widths, constants and pair tables of the ultrasonic pair
// trilateration and fusion block.
// ============================================================================
package upt_pkg;

    // sensor and pair counts
    localparam int NUM_ECHO    = 4;
    localparam int NUM_SENSORS = 4;
    localparam int NUM_PAIRS   = 6;

    // port widths
    localparam int ECHO_W     = 13;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // range conversion: range_q4 = width * 343 / 125
    localparam int ECHO_LIMIT  = 5000;
    localparam int SOUND_NUM   = 343;
    localparam int RANGE_DEN   = 125;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_K     = (1 << RECIP_SHIFT) / RANGE_DEN;
    localparam int PROD_W      = 21;
    localparam int RECIP_W     = 42;

    // pair datapath widths
    localparam int RNG_W  = 14;
    localparam int A_W    = POS_W + 4;
    localparam int DEN_W  = POS_W + 5;
    localparam int SQ_W   = 28;
    localparam int NUM_W  = SQ_W + 1;
    localparam int XQ_W   = 14;
    localparam int ROOT_W = 14;
    localparam int X_W    = XQ_W + 2;
    localparam int WX_W   = X_W + POS_W + 1;
    localparam int WY_W   = ROOT_W + POS_W;

    // fusion widths
    localparam int SX_W = WX_W + 2;
    localparam int SY_W = WY_W + 3;
    localparam int SW_W = POS_W + 3;
    localparam int FQ_W = 15;

    // output limits
    localparam int X_MAX = 32767;
    localparam int X_MIN = -32768;
    localparam int Y_MAX = 16383;

    // pipeline depth of each unit
    localparam int RNG_LAT   = 3;
    localparam int PAIR_LAT  = XQ_W + ROOT_W + 5;
    localparam int FUSE_LAT  = FQ_W + 3;
    localparam int TOTAL_LAT = RNG_LAT + PAIR_LAT + FUSE_LAT;

    typedef logic [1:0]         sidx_t;
    typedef logic [RNG_W-1:0]   rng_t;
    typedef logic [POS_W-1:0]   pos_t;

    // sensors of each pair, pairs in order 01,02,03,12,13,23
    localparam sidx_t PAIR_LO [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam sidx_t PAIR_HI [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR0_POS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR1_POS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR2_POS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR3_POS = 8'd3;

    // register reset values
    localparam pos_t POS_RST [NUM_ECHO] = '{10'd0, 10'd41, 10'd85, 10'd130};

    typedef struct packed {
        logic [ECHO_W-1:0] echo_width0;
        logic [ECHO_W-1:0] echo_width1;
        logic [ECHO_W-1:0] echo_width2;
        logic [ECHO_W-1:0] echo_width3;
    } upt_in_t;

    typedef struct packed {
        logic signed [15:0]     target_x;
        logic [13:0]            target_y;
        logic [NUM_PAIRS-1:0]   pair_valid_mask;
        logic                   fix_valid;
    } upt_out_t;

endpackage

FILE: src/upt_range.sv
// ============================================================================
// upt_range
// Converts the four echo widths to ranges in Q.4 millimetres, three stages:
// constant multiply, reciprocal multiply, remainder correction.
// ============================================================================
module upt_range (
    input  logic                                                aclk,
    input  logic                                                en,
    input  upt_pkg::upt_in_t                                    echo_i,
    output logic [upt_pkg::NUM_ECHO-1:0][upt_pkg::RNG_W-1:0]    rng_o
);

    logic [upt_pkg::ECHO_W-1:0] echo [upt_pkg::NUM_ECHO];

    // lane split
    always_comb begin
        echo[0] = echo_i.echo_width0;
        echo[1] = echo_i.echo_width1;
        echo[2] = echo_i.echo_width2;
        echo[3] = echo_i.echo_width3;
    end

    for (genvar g = 0; g < upt_pkg::NUM_ECHO; g++) begin : g_lane
        logic [upt_pkg::PROD_W-1:0]  n_reg, n_next, n2_reg;
        logic [upt_pkg::RECIP_W-1:0] p_reg, p_next;
        logic [upt_pkg::RNG_W-1:0]   q0, rng_reg, rng_next;
        logic [upt_pkg::PROD_W-1:0]  q125, rem;

        // width times 343, overlong echo gives zero
        assign n_next = (echo[g] > upt_pkg::ECHO_W'(upt_pkg::ECHO_LIMIT)) ? '0 :
                        upt_pkg::PROD_W'(echo[g]) * upt_pkg::PROD_W'(upt_pkg::SOUND_NUM);

        // reciprocal of 125, estimate low by at most one
        assign p_next = upt_pkg::RECIP_W'(n_reg) * upt_pkg::RECIP_W'(upt_pkg::RECIP_K);

        // remainder check fixes the estimate
        assign q0   = p_reg[upt_pkg::RECIP_SHIFT +: upt_pkg::RNG_W];
        assign q125 = (upt_pkg::PROD_W'(q0) << 7) - (upt_pkg::PROD_W'(q0) << 2)
                      + upt_pkg::PROD_W'(q0);
        assign rem  = n2_reg - q125;
        assign rng_next = (rem >= upt_pkg::PROD_W'(upt_pkg::RANGE_DEN)) ?
                          q0 + upt_pkg::RNG_W'(1) : q0;

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg   <= n_next;
                p_reg   <= p_next;
                n2_reg  <= n_reg;
                rng_reg <= rng_next;
            end
        end

        assign rng_o[g] = rng_reg;
    end

endmodule

FILE: src/upt_pair.sv
// ============================================================================
// upt_pair
// One sensor pair: triangle test, x offset by a pipelined restoring divider,
// y by a pipelined square root, then baseline weighting.
// ============================================================================
module upt_pair (
    input  logic                                aclk,
    input  logic                                en,
    input  upt_pkg::rng_t                       r1_i,
    input  upt_pkg::rng_t                       r2_i,
    input  upt_pkg::pos_t                       base_i,
    input  upt_pkg::pos_t                       pos_i,
    output logic                                ok_o,
    output logic signed [upt_pkg::WX_W-1:0]     wx_o,
    output logic [upt_pkg::WY_W-1:0]            wy_o
);

    localparam int NQ = upt_pkg::XQ_W;
    localparam int NR = upt_pkg::ROOT_W;

    // baseline in q.4 and triangle test
    logic [upt_pkg::A_W-1:0] a;
    logic [upt_pkg::A_W:0]   r1e, r2e, ae, r2a, r1a, r12;
    logic                    ok1_next;

    assign a   = {base_i, 4'b0000};
    assign r1e = (upt_pkg::A_W + 1)'(r1_i);
    assign r2e = (upt_pkg::A_W + 1)'(r2_i);
    assign ae  = (upt_pkg::A_W + 1)'(a);
    assign r2a = r2e + ae;
    assign r1a = r1e + ae;
    assign r12 = r1e + r2e;
    assign ok1_next = (base_i != '0) && (r1_i != '0) && (r2_i != '0) &&
                      (r1e <= r2a) && (r2e <= r1a) && (ae <= r12);

    // squares
    logic [upt_pkg::SQ_W-1:0] r1sq1_reg, r2sq1_reg, asq1_reg;
    logic                     ok1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r1sq1_reg <= upt_pkg::SQ_W'(r1_i) * upt_pkg::SQ_W'(r1_i);
            r2sq1_reg <= upt_pkg::SQ_W'(r2_i) * upt_pkg::SQ_W'(r2_i);
            asq1_reg  <= upt_pkg::SQ_W'(a) * upt_pkg::SQ_W'(a);
            ok1_reg   <= ok1_next;
        end
    end

    // numerator as sign and magnitude
    logic signed [upt_pkg::NUM_W:0] num_s;
    logic [upt_pkg::NUM_W-1:0]      num_mag;
    logic [upt_pkg::DEN_W-1:0]      den;

    assign num_s   = $signed({2'b00, r1sq1_reg}) + $signed({2'b00, asq1_reg})
                     - $signed({2'b00, r2sq1_reg});
    assign num_mag = num_s[upt_pkg::NUM_W] ? upt_pkg::NUM_W'(-num_s) :
                                             upt_pkg::NUM_W'(num_s);
    assign den     = {base_i, 5'b00000};

    // divider pipeline, one quotient bit per stage
    logic [upt_pkg::NUM_W-1:0] drem_reg  [0:NQ];
    logic [upt_pkg::XQ_W-1:0]  dq_reg    [0:NQ];
    logic                      dneg_reg  [0:NQ];
    logic [upt_pkg::SQ_W-1:0]  dr1sq_reg [0:NQ];
    logic                      dok_reg   [0:NQ];

    always_ff @(posedge aclk) begin
        if (en) begin
            drem_reg[0]  <= num_mag;
            dq_reg[0]    <= '0;
            dneg_reg[0]  <= num_s[upt_pkg::NUM_W];
            dr1sq_reg[0] <= r1sq1_reg;
            dok_reg[0]   <= ok1_reg;
        end
    end

    for (genvar s = 1; s <= NQ; s++) begin : g_div
        localparam int B = NQ - s;
        logic [upt_pkg::NUM_W-1:0] dsh;
        logic                      take;

        assign dsh  = upt_pkg::NUM_W'(den) << B;
        assign take = drem_reg[s-1] >= dsh;

        always_ff @(posedge aclk) begin
            if (en) begin
                drem_reg[s]  <= take ? drem_reg[s-1] - dsh : drem_reg[s-1];
                dq_reg[s]    <= take ? (dq_reg[s-1] | (upt_pkg::XQ_W'(1) << B)) :
                                       dq_reg[s-1];
                dneg_reg[s]  <= dneg_reg[s-1];
                dr1sq_reg[s] <= dr1sq_reg[s-1];
                dok_reg[s]   <= dok_reg[s-1];
            end
        end
    end

    // signed offset, absolute x and offset square
    logic [upt_pkg::XQ_W-1:0]      qv;
    logic signed [upt_pkg::X_W-1:0] xoff_s, x_next;
    logic signed [upt_pkg::X_W-1:0] qx_reg;
    logic [upt_pkg::SQ_W-1:0]      qxsq_reg, qr1sq_reg;
    logic                          qok_reg;

    assign qv     = dq_reg[NQ];
    assign xoff_s = dneg_reg[NQ] ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
    assign x_next = xoff_s + $signed({2'b00, pos_i, 4'b0000});

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg    <= x_next;
            qxsq_reg  <= upt_pkg::SQ_W'(qv) * upt_pkg::SQ_W'(qv);
            qr1sq_reg <= dr1sq_reg[NQ];
            qok_reg   <= dok_reg[NQ];
        end
    end

    // radicand clamped at zero
    logic signed [upt_pkg::SQ_W:0] rad_s;
    logic [upt_pkg::SQ_W-1:0]      rad;

    assign rad_s = $signed({1'b0, qr1sq_reg}) - $signed({1'b0, qxsq_reg});
    assign rad   = rad_s[upt_pkg::SQ_W] ? '0 : rad_s[upt_pkg::SQ_W-1:0];

    // square root pipeline, one root bit per stage
    logic [upt_pkg::SQ_W-1:0]       srem_reg  [0:NR];
    logic [upt_pkg::ROOT_W-1:0]     sroot_reg [0:NR];
    logic signed [upt_pkg::X_W-1:0] sx_reg    [0:NR];
    logic                           sok_reg   [0:NR];

    always_ff @(posedge aclk) begin
        if (en) begin
            srem_reg[0]  <= rad;
            sroot_reg[0] <= '0;
            sx_reg[0]    <= qx_reg;
            sok_reg[0]   <= qok_reg;
        end
    end

    for (genvar s = 1; s <= NR; s++) begin : g_sqrt
        localparam int B = NR - s;
        logic [upt_pkg::SQ_W:0] trial;
        logic                   take;

        assign trial = ((upt_pkg::SQ_W + 1)'(sroot_reg[s-1]) << (B + 1))
                       + ((upt_pkg::SQ_W + 1)'(1) << (2 * B));
        assign take  = {1'b0, srem_reg[s-1]} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                srem_reg[s]  <= take ? srem_reg[s-1] - trial[upt_pkg::SQ_W-1:0] :
                                       srem_reg[s-1];
                sroot_reg[s] <= take ? (sroot_reg[s-1] | (upt_pkg::ROOT_W'(1) << B)) :
                                       sroot_reg[s-1];
                sx_reg[s]    <= sx_reg[s-1];
                sok_reg[s]   <= sok_reg[s-1];
            end
        end
    end

    // baseline weighting, invalid pair weighs nothing
    logic signed [upt_pkg::WX_W-1:0] wx_next, mwx_reg;
    logic [upt_pkg::WY_W-1:0]        wy_next, mwy_reg;
    logic                            mok_reg;

    assign wx_next = sok_reg[NR] ? $signed(sx_reg[NR]) * $signed({1'b0, base_i})
                                 : $signed(upt_pkg::WX_W'(0));
    assign wy_next = sok_reg[NR] ? upt_pkg::WY_W'(sroot_reg[NR]) * upt_pkg::WY_W'(base_i)
                                 : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            mwx_reg <= wx_next;
            mwy_reg <= wy_next;
            mok_reg <= sok_reg[NR];
        end
    end

    assign ok_o = mok_reg;
    assign wx_o = mwx_reg;
    assign wy_o = mwy_reg;

endmodule

FILE: src/upt_fuse.sv
// ============================================================================
// upt_fuse
// Baseline weighted average of the pair points: adder tree, two pipelined
// dividers by the weight sum, then rounding toward zero and saturation.
// ============================================================================
module upt_fuse (
    input  logic                                                    aclk,
    input  logic                                                    en,
    input  logic [upt_pkg::NUM_PAIRS-1:0]                           ok_i,
    input  logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::WX_W-1:0]        wx_i,
    input  logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::WY_W-1:0]        wy_i,
    input  logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::POS_W-1:0]       base_i,
    output upt_pkg::upt_out_t                                       out_o
);

    localparam int NH = upt_pkg::NUM_PAIRS / 2;
    localparam int NF = upt_pkg::FQ_W;

    // first adder level
    logic signed [upt_pkg::WX_W:0]  px_next [NH];
    logic [upt_pkg::WY_W:0]         py_next [NH];
    logic [upt_pkg::POS_W:0]        pw_next [NH];
    logic signed [upt_pkg::WX_W:0]  px_reg  [NH];
    logic [upt_pkg::WY_W:0]         py_reg  [NH];
    logic [upt_pkg::POS_W:0]        pw_reg  [NH];
    logic [upt_pkg::NUM_PAIRS-1:0]  mask1_reg;
    logic [upt_pkg::POS_W-1:0]      wg0, wg1;

    always_comb begin
        for (int h = 0; h < NH; h++) begin
            wg0 = ok_i[2*h] ? base_i[2*h] : '0;
            wg1 = ok_i[2*h+1] ? base_i[2*h+1] : '0;
            px_next[h] = (upt_pkg::WX_W + 1)'($signed(wx_i[2*h]))
                         + (upt_pkg::WX_W + 1)'($signed(wx_i[2*h+1]));
            py_next[h] = (upt_pkg::WY_W + 1)'(wy_i[2*h]) + (upt_pkg::WY_W + 1)'(wy_i[2*h+1]);
            pw_next[h] = (upt_pkg::POS_W + 1)'(wg0) + (upt_pkg::POS_W + 1)'(wg1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            pw_reg    <= pw_next;
            mask1_reg <= ok_i;
        end
    end

    // totals, x as sign and magnitude
    logic signed [upt_pkg::SX_W-1:0] sx;
    logic [upt_pkg::SY_W-1:0]        sy;
    logic [upt_pkg::SW_W-1:0]        sw;
    logic [upt_pkg::SX_W-1:0]        sx_mag;

    assign sx = upt_pkg::SX_W'(px_reg[0]) + upt_pkg::SX_W'(px_reg[1])
                + upt_pkg::SX_W'(px_reg[2]);
    assign sy = upt_pkg::SY_W'(py_reg[0]) + upt_pkg::SY_W'(py_reg[1])
                + upt_pkg::SY_W'(py_reg[2]);
    assign sw = upt_pkg::SW_W'(pw_reg[0]) + upt_pkg::SW_W'(pw_reg[1])
                + upt_pkg::SW_W'(pw_reg[2]);
    assign sx_mag = sx[upt_pkg::SX_W-1] ? upt_pkg::SX_W'(-sx) : upt_pkg::SX_W'(sx);

    // two dividers side by side, one quotient bit per stage
    logic [upt_pkg::SX_W-1:0]      xrem_reg [0:NF];
    logic [upt_pkg::FQ_W-1:0]      xq_reg   [0:NF];
    logic [upt_pkg::SY_W-1:0]      yrem_reg [0:NF];
    logic [upt_pkg::FQ_W-1:0]      yq_reg   [0:NF];
    logic [upt_pkg::SW_W-1:0]      sw_reg   [0:NF];
    logic                          neg_reg  [0:NF];
    logic [upt_pkg::NUM_PAIRS-1:0] mask_reg [0:NF];

    always_ff @(posedge aclk) begin
        if (en) begin
            xrem_reg[0] <= sx_mag;
            xq_reg[0]   <= '0;
            yrem_reg[0] <= sy;
            yq_reg[0]   <= '0;
            sw_reg[0]   <= sw;
            neg_reg[0]  <= sx[upt_pkg::SX_W-1];
            mask_reg[0] <= mask1_reg;
        end
    end

    for (genvar s = 1; s <= NF; s++) begin : g_div
        localparam int B = NF - s;
        logic [upt_pkg::SX_W-1:0] xsh;
        logic [upt_pkg::SY_W-1:0] ysh;
        logic                     xtake, ytake;

        assign xsh   = upt_pkg::SX_W'(sw_reg[s-1]) << B;
        assign ysh   = upt_pkg::SY_W'(sw_reg[s-1]) << B;
        assign xtake = xrem_reg[s-1] >= xsh;
        assign ytake = yrem_reg[s-1] >= ysh;

        always_ff @(posedge aclk) begin
            if (en) begin
                xrem_reg[s] <= xtake ? xrem_reg[s-1] - xsh : xrem_reg[s-1];
                xq_reg[s]   <= xtake ? (xq_reg[s-1] | (upt_pkg::FQ_W'(1) << B)) : xq_reg[s-1];
                yrem_reg[s] <= ytake ? yrem_reg[s-1] - ysh : yrem_reg[s-1];
                yq_reg[s]   <= ytake ? (yq_reg[s-1] | (upt_pkg::FQ_W'(1) << B)) : yq_reg[s-1];
                sw_reg[s]   <= sw_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                mask_reg[s] <= mask_reg[s-1];
            end
        end
    end

    // sign, saturation, no-fix zeroing
    logic signed [upt_pkg::FQ_W+1:0] fx;
    upt_pkg::upt_out_t               res_next, res_reg;

    assign fx = neg_reg[NF] ? -$signed({2'b00, xq_reg[NF]}) : $signed({2'b00, xq_reg[NF]});

    always_comb begin
        res_next                 = '0;
        res_next.pair_valid_mask = mask_reg[NF];
        if (sw_reg[NF] != '0) begin
            res_next.fix_valid = 1'b1;
            if (fx > (upt_pkg::FQ_W + 2)'(upt_pkg::X_MAX)) begin
                res_next.target_x = 16'(upt_pkg::X_MAX);
            end else if (fx < (upt_pkg::FQ_W + 2)'(upt_pkg::X_MIN)) begin
                res_next.target_x = 16'(upt_pkg::X_MIN);
            end else begin
                res_next.target_x = 16'(fx);
            end
            if (yq_reg[NF] > upt_pkg::FQ_W'(upt_pkg::Y_MAX)) begin
                res_next.target_y = 14'(upt_pkg::Y_MAX);
            end else begin
                res_next.target_y = yq_reg[NF][13:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_o = res_reg;

endmodule

FILE: src/ultrasonic_pair_trilateration_fusion.sv
// ============================================================================
// ultrasonic_pair_trilateration_fusion
// Echo widths of four sensors on a line to a baseline weighted target fix.
//
//   channel  ports                               moves
//   -------  ----------------------------------  -----------------------------
//   input    s_valid s_ready s_data              four echo widths, one item
//   result   m_valid m_ready m_data              x, y, pair mask, fix flag
//   config   cfg_valid cfg_ready cfg_index/data  sensor positions 0..3
//
// one item per cycle while the enable is high; an accepted item passes through
// 3 range, 33 pair and 18 fusion stages and then the output register, the first
// stage loaded at the accepting edge
// the whole pipeline moves on one enable, held low only while the output
// register and the skid register both hold items
// reset (aresetn low, synchronous) empties the pipeline and loads the
// default sensor positions; configuration writes are taken every cycle
// ============================================================================
module ultrasonic_pair_trilateration_fusion (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  upt_pkg::upt_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output upt_pkg::upt_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [upt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [upt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic en;

    // sensor position registers
    upt_pkg::pos_t pos_reg [upt_pkg::NUM_ECHO];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < upt_pkg::NUM_ECHO; i++) begin
                pos_reg[i] <= upt_pkg::POS_RST[i];
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                upt_pkg::REG_SENSOR0_POS: pos_reg[0] <= cfg_data[upt_pkg::POS_W-1:0];
                upt_pkg::REG_SENSOR1_POS: pos_reg[1] <= cfg_data[upt_pkg::POS_W-1:0];
                upt_pkg::REG_SENSOR2_POS: pos_reg[2] <= cfg_data[upt_pkg::POS_W-1:0];
                upt_pkg::REG_SENSOR3_POS: pos_reg[3] <= cfg_data[upt_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // baselines per pair, zero when not positive
    logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::POS_W-1:0] base;
    logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::POS_W-1:0] pos_lo;

    for (genvar k = 0; k < upt_pkg::NUM_PAIRS; k++) begin : g_base
        assign pos_lo[k] = pos_reg[upt_pkg::PAIR_LO[k]];
        assign base[k]   = (pos_reg[upt_pkg::PAIR_HI[k]] > pos_reg[upt_pkg::PAIR_LO[k]]) ?
                           pos_reg[upt_pkg::PAIR_HI[k]] - pos_reg[upt_pkg::PAIR_LO[k]] : '0;
    end

    // echo widths to ranges
    logic [upt_pkg::NUM_ECHO-1:0][upt_pkg::RNG_W-1:0] rng;

    upt_range u_range (
        .aclk   (aclk),
        .en     (en),
        .echo_i (s_data),
        .rng_o  (rng)
    );

    // pair units
    logic [upt_pkg::NUM_PAIRS-1:0]                    ok;
    logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::WX_W-1:0] wx;
    logic [upt_pkg::NUM_PAIRS-1:0][upt_pkg::WY_W-1:0] wy;

    for (genvar k = 0; k < upt_pkg::NUM_PAIRS; k++) begin : g_pair
        if (int'(upt_pkg::PAIR_HI[k]) < upt_pkg::NUM_SENSORS) begin : g_on
            upt_pair u_pair (
                .aclk   (aclk),
                .en     (en),
                .r1_i   (rng[upt_pkg::PAIR_LO[k]]),
                .r2_i   (rng[upt_pkg::PAIR_HI[k]]),
                .base_i (base[k]),
                .pos_i  (pos_lo[k]),
                .ok_o   (ok[k]),
                .wx_o   (wx[k]),
                .wy_o   (wy[k])
            );
        end else begin : g_off
            assign ok[k] = 1'b0;
            assign wx[k] = '0;
            assign wy[k] = '0;
        end
    end

    // fusion
    upt_pkg::upt_out_t fused;

    upt_fuse u_fuse (
        .aclk   (aclk),
        .en     (en),
        .ok_i   (ok),
        .wx_i   (wx),
        .wy_i   (wy),
        .base_i (base),
        .out_o  (fused)
    );

    // valid line alongside the datapath
    logic vld_reg [0:upt_pkg::TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < upt_pkg::TOTAL_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < upt_pkg::TOTAL_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // output register with skid register
    logic              out_valid_reg, skid_valid_reg, pipe_valid, pop;
    upt_pkg::upt_out_t out_reg, skid_reg;

    assign en         = !skid_valid_reg;
    assign s_ready    = en;
    assign pipe_valid = vld_reg[upt_pkg::TOTAL_LAT-1] && en;
    assign pop        = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg <= fused;
            end else begin
                skid_reg <= fused;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: dv/tb_ultrasonic_pair_trilateration_fusion.sv
// ============================================================================
// tb_ultrasonic_pair_trilateration_fusion
// Self-checking bench for the ultrasonic pair trilateration and fusion block.
// A directed table runs at the reset sensor positions. Random phases follow,
// each with new sensor positions written while the pipeline is empty. Every
// accepted item is predicted in the bench and its result is checked in order.
// Both channels idle and stall at random.
// ============================================================================
`timescale 1ns / 100ps

module tb_ultrasonic_pair_trilateration_fusion;
    import upt_pkg::*;

    localparam int PHASE_ITEMS = 170;
    localparam int DRAIN_WAIT  = 70;

    typedef struct {
        upt_in_t  din;
        bit       known;
        upt_out_t dout;
    } vec_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    upt_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    upt_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pos_t     sensor_pos [NUM_ECHO];
    upt_out_t fix_queue [$];
    int       mismatches = 0;
    int       results_seen = 0;
    int       fixes_seen = 0;
    int       items_sent = 0;
    int       burst_left = 0;
    int       stall_mode = 0;
    int       stall_tick = 0;

    ultrasonic_pair_trilateration_fusion u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard time limit
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // echo width in us to range in q.4 mm
    function automatic longint echo_range(logic [ECHO_W-1:0] w);
        if (w > ECHO_LIMIT) return 0;
        return (longint'(w) * SOUND_NUM * 16) / 2000;
    endfunction

    // baseline weighted fusion of all valid pair fixes
    function automatic upt_out_t fuse_fix(upt_in_t d);
        longint   rng [NUM_ECHO];
        longint   sum_x, sum_y, sum_w;
        longint   pi, pj, w, a, r1, r2, xoff, rad, fx, fy;
        upt_out_t res;
        res = '0;
        sum_x = 0;
        sum_y = 0;
        sum_w = 0;
        rng[0] = echo_range(d.echo_width0);
        rng[1] = echo_range(d.echo_width1);
        rng[2] = echo_range(d.echo_width2);
        rng[3] = echo_range(d.echo_width3);
        for (int k = 0; k < NUM_PAIRS; k++) begin
            if (int'(PAIR_HI[k]) >= NUM_SENSORS) continue;
            pi = sensor_pos[PAIR_LO[k]];
            pj = sensor_pos[PAIR_HI[k]];
            w  = pj - pi;
            a  = w * 16;
            r1 = rng[PAIR_LO[k]];
            r2 = rng[PAIR_HI[k]];
            if (r1 == 0 || r2 == 0 || w <= 0) continue;
            if (r1 > r2 + a || r2 > r1 + a || a > r1 + r2) continue;
            // signed division truncates toward zero
            xoff = (r1 * r1 + a * a - r2 * r2) / (2 * a);
            rad  = r1 * r1 - xoff * xoff;
            if (rad < 0) rad = 0;
            sum_x += (xoff + pi * 16) * w;
            sum_y += longint'(int_sqrt(rad)) * w;
            sum_w += w;
            res.pair_valid_mask[k] = 1'b1;
        end
        if (sum_w > 0) begin
            fx = sum_x / sum_w;
            fy = sum_y / sum_w;
            if (fx > X_MAX) fx = X_MAX;
            if (fx < X_MIN) fx = X_MIN;
            if (fy > Y_MAX) fy = Y_MAX;
            if (fy < 0) fy = 0;
            res.target_x  = fx[15:0];
            res.target_y  = fy[13:0];
            res.fix_valid = 1'b1;
        end
        return res;
    endfunction

    // echo widths of a target point seen from the current sensor positions
    function automatic logic [ECHO_W-1:0] echo_of(int tx, int ty, int s);
        int dx, span, wid;
        dx   = tx - int'(sensor_pos[s]);
        span = int'(int_sqrt(longint'(dx * dx + ty * ty)));
        wid  = span * 2000 / 343 + int'($urandom_range(0, 6)) - 3;
        if (wid < 1) wid = 1;
        if (wid > ECHO_LIMIT) wid = ECHO_LIMIT;
        return wid[ECHO_W-1:0];
    endfunction

    function automatic upt_in_t target_item();
        upt_in_t d;
        int tx, ty;
        tx = $urandom_range(0, 1150);
        ty = $urandom_range(0, 900);
        d.echo_width0 = echo_of(tx, ty, 0);
        d.echo_width1 = echo_of(tx, ty, 1);
        d.echo_width2 = echo_of(tx, ty, 2);
        d.echo_width3 = echo_of(tx, ty, 3);
        return d;
    endfunction

    // mostly geometric sets, the rest noise and dropouts
    function automatic upt_in_t random_item();
        upt_in_t d;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            d = target_item();
        end else if (pick < 85) begin
            d = upt_in_t'({$urandom, $urandom});
        end else begin
            d = target_item();
            if ($urandom_range(0, 1)) d.echo_width0 = '0;
            if ($urandom_range(0, 1)) d.echo_width1 = '0;
            if ($urandom_range(0, 1)) d.echo_width2 = '0;
            if ($urandom_range(0, 1)) d.echo_width3 = ECHO_LIMIT + 1;
        end
        return d;
    endfunction

    // result checker and config shadow
    always @(posedge aclk) begin
        upt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_data.fix_valid) fixes_seen++;
            if (fix_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", m_data);
            end else begin
                want = fix_queue.pop_front();
                if (m_data.target_x !== want.target_x ||
                    m_data.target_y !== want.target_y ||
                    m_data.pair_valid_mask !== want.pair_valid_mask ||
                    m_data.fix_valid !== want.fix_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d mask=%b fix=%b, got x=%0d y=%0d mask=%b fix=%b",
                                 want.target_x, want.target_y, want.pair_valid_mask,
                                 want.fix_valid, m_data.target_x, m_data.target_y,
                                 m_data.pair_valid_mask, m_data.fix_valid);
                end
            end
        end
        if (aresetn && cfg_valid && cfg_ready && cfg_index < NUM_ECHO)
            sensor_pos[cfg_index] <= cfg_data[POS_W-1:0];
    end

    // receiver stall pattern, in one of four modes drawn at random
    always @(negedge aclk) begin
        stall_tick++;
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready = 1'b1;
            1: m_ready = 1'($urandom_range(0, 1));
            2: m_ready = ($urandom_range(0, 9) < 2);
            default: m_ready = ((stall_tick % 16) < 12);
        endcase
    end

    // one item on the input channel, with burst gaps before it
    task automatic send_item(upt_in_t d, bit known, upt_out_t kv);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_data  = d;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        fix_queue.push_back(known ? kv : fuse_fix(d));
        items_sent++;
        @(negedge aclk);
    endtask

    // new sensor positions once the pipeline has drained
    task automatic set_positions(int p0, int p1, int p2, int p3);
        logic [CFG_IDX_W-1:0] regs [NUM_ECHO];
        int vals [NUM_ECHO];
        regs = '{REG_SENSOR0_POS, REG_SENSOR1_POS, REG_SENSOR2_POS, REG_SENSOR3_POS};
        vals = '{p0, p1, p2, p3};
        s_valid = 1'b0;
        burst_left = 0;
        while (fix_queue.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        for (int i = 0; i <= NUM_ECHO; i++) begin
            cfg_valid = 1'b1;
            if (i < NUM_ECHO) begin
                cfg_index = regs[i];
                // upper data bits are don't care
                cfg_data  = {6'($urandom_range(0, 63)), vals[i][POS_W-1:0]};
            end else begin
                // out of range index must be ignored
                cfg_index = CFG_IDX_W'($urandom_range(NUM_ECHO, 255));
                cfg_data  = CFG_DATA_W'($urandom);
            end
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
        end
        cfg_valid = 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        vec_t     dir_tbl [$];
        upt_in_t  d;
        upt_out_t z;
        int       ps [4];
        z = '0;
        sensor_pos = POS_RST;

        // directed rows: expected typed in only for the no-fix cases
        dir_tbl.push_back('{'{0, 0, 0, 0}, 1, z});
        dir_tbl.push_back('{'{5001, 5001, 5001, 5001}, 1, z});
        dir_tbl.push_back('{'{8191, 8191, 8191, 8191}, 1, z});
        dir_tbl.push_back('{'{1, 1, 1, 1}, 1, z});
        dir_tbl.push_back('{'{0, 1000, 0, 0}, 1, z});
        dir_tbl.push_back('{'{5000, 5000, 5000, 5000}, 0, z});
        dir_tbl.push_back('{'{5000, 0, 5000, 8191}, 0, z});
        dir_tbl.push_back('{'{1000, 1000, 1000, 1000}, 0, z});
        dir_tbl.push_back('{'{300, 320, 350, 400}, 0, z});
        dir_tbl.push_back('{'{400, 350, 320, 300}, 0, z});
        dir_tbl.push_back('{'{100, 5000, 100, 5000}, 0, z});
        dir_tbl.push_back('{'{4096, 2048, 1024, 512}, 0, z});
        dir_tbl.push_back('{'{5000, 4999, 1, 5000}, 0, z});
        dir_tbl.push_back('{'{0, 300, 310, 330}, 0, z});
        dir_tbl.push_back('{'{300, 310, 330, 0}, 0, z});
        dir_tbl.push_back('{'{2730, 2730, 2730, 2730}, 0, z});

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_tbl[i]) send_item(dir_tbl[i].din, dir_tbl[i].known, dir_tbl[i].dout);
        repeat (PHASE_ITEMS) send_item(random_item(), 0, z);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: ps = '{0, 343, 686, 1023};
                1: ps = '{0, 0, 0, 0};
                2: ps = '{1023, 1023, 1023, 1023};
                3: ps = '{1023, 700, 300, 0};
                4: ps = '{0, 1, 2, 3};
                default: begin
                    foreach (ps[j]) ps[j] = $urandom_range(0, 1023);
                    if ($urandom_range(0, 4) != 0) ps.sort();
                end
            endcase
            set_positions(ps[0], ps[1], ps[2], ps[3]);
            if (ph == 0) begin
                // ranges that meet the triangle bound exactly
                d = '{125, 2125, 4125, 125};
                send_item(d, 0, z);
                d = '{2125, 125, 4125, 2125};
                send_item(d, 0, z);
            end
            repeat (PHASE_ITEMS) send_item(random_item(), 0, z);
        end

        s_valid = 1'b0;
        while (fix_queue.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        $display("sent %0d echo sets over 10 sensor layouts, checked %0d results (%0d fixes)",
                 items_sent, results_seen, fixes_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
src/upt_pkg.sv
src/upt_range.sv
src/upt_pair.sv
src/upt_fuse.sv
src/ultrasonic_pair_trilateration_fusion.sv
dv/tb_ultrasonic_pair_trilateration_fusion.sv
